FILE: rtl/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// shared types, codes and constants of the servo reply frame checker
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int MAX_PARAMS  = 4;
    localparam int PARAM_SLOTS = 4;
    localparam int PIDX_W      = $clog2(PARAM_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] HDR_BYTE       = 8'h55;
    localparam logic [7:0] ANY_ID         = 8'hfe;
    localparam logic [7:0] LEN_MIN        = 8'd3;
    localparam logic [7:0] LEN_MAX        = 8'd7;
    localparam logic [3:0] FRAME_OVERHEAD = 4'd6;
    localparam logic [3:0] FRAME_LEN_INIT = 4'd7;

    // input selector codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_ID       = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_COMMAND  = 3'd5;
    localparam logic [2:0] ST_CHECKSUM = 3'd6;
    localparam logic [2:0] ST_TIMEOUT  = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CMD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_BYTE_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_MS       = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] param_0;
        logic [7:0] param_1;
        logic [7:0] param_2;
        logic [7:0] param_3;
        logic [2:0] param_count;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } q_entry_t;

    typedef struct packed {
        logic [7:0] expected_id;
        logic [7:0] expected_cmd;
        logic [2:0] expected_param_count;
        logic [7:0] per_byte_ms;
        logic [7:0] extra_ms;
    } cfg_t;

endpackage

FILE: rtl/srfc_front.sv
// ----------------------------------------------------------------------------
// srfc_front
// accepts input words, decodes the selector and pushes operations to the queue
// ----------------------------------------------------------------------------
module srfc_front
(
    input  srfc_pkg::in_item_t in_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               q_full,
    output logic               push,
    output srfc_pkg::q_entry_t push_entry
);
    import srfc_pkg::*;

    logic is_op;

    always_comb
    begin
        is_op            = 1'b1;
        push_entry.op    = OP_START;
        push_entry.rx_byte = in_data.rx_byte;
        unique case (in_data.func)
            FUNC_START: push_entry.op = OP_START;
            FUNC_BYTE:  push_entry.op = OP_BYTE;
            FUNC_TICK:  push_entry.op = OP_TICK;
            default:    is_op = 1'b0;   // unused selector is dropped here
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && is_op;

endmodule

FILE: rtl/srfc_queue.sv
// ----------------------------------------------------------------------------
// srfc_queue
// short flip-flop queue between the front and back parts
// ----------------------------------------------------------------------------
module srfc_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  srfc_pkg::q_entry_t         push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output srfc_pkg::q_entry_t         head_entry,
    output logic                       full,
    output logic [srfc_pkg::QCNT_W-1:0] level
);
    import srfc_pkg::*;

    q_entry_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign level      = count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/srfc_back.sv
// ----------------------------------------------------------------------------
// srfc_back
// frame state, per-byte checks, timeout count and the output register
// ----------------------------------------------------------------------------
module srfc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  srfc_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  srfc_pkg::q_entry_t  head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output srfc_pkg::out_item_t out_data
);
    import srfc_pkg::*;

    logic            active_reg, active_next;
    logic [3:0]      pos_reg, pos_next;
    logic [3:0]      flen_reg, flen_next;
    logic [7:0]      sum_reg, sum_next;
    logic [11:0]     time_reg, time_next;
    logic [7:0]      store_reg [PARAM_SLOTS];
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic [2:0]      eff_count;
    logic [3:0]      len_limit;
    logic [11:0]     timeout;
    logic [11:0]     time_dec;
    logic [3:0]      len_calc;
    logic [3:0]      slot;
    logic [2:0]      n_params;
    logic            finish;
    logic [2:0]      fin_status;
    logic            advance;
    logic            store_we;
    logic [7:0]      b;

    assign pop = head_valid && (!out_valid_reg || !out_stall);
    assign b   = head_entry.rx_byte;

    always_comb
    begin
        eff_count = (cfg.expected_param_count > 3'(MAX_PARAMS)) ?
                    3'(MAX_PARAMS) : cfg.expected_param_count;
        len_limit = {1'b0, eff_count} + FRAME_OVERHEAD;
        timeout   = 12'(cfg.per_byte_ms) * 12'(len_limit) + 12'(cfg.extra_ms);
        time_dec  = (time_reg != '0) ? time_reg - 1'b1 : '0;
        len_calc  = b[3:0] + 4'd3;
        slot      = pos_reg - 4'd5;
        n_params  = flen_reg[2:0] - FRAME_OVERHEAD[2:0];
        if (n_params > 3'(PARAM_SLOTS))
        begin
            n_params = 3'(PARAM_SLOTS);
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        pos_next       = pos_reg;
        flen_next      = flen_reg;
        sum_next       = sum_reg;
        time_next      = time_reg;
        finish         = 1'b0;
        fin_status     = ST_OK;
        advance        = 1'b0;
        store_we       = 1'b0;

        if (pop)
        begin
            if (head_entry.op == OP_START)
            begin
                time_next   = timeout;
                pos_next    = '0;
                flen_next   = FRAME_LEN_INIT;
                sum_next    = '0;
                active_next = 1'b1;
                if (timeout == '0)
                begin
                    finish     = 1'b1;
                    fin_status = ST_TIMEOUT;
                end
            end
            else if (active_reg)
            begin
                if (head_entry.op == OP_TICK)
                begin
                    time_next = time_dec;
                    if (time_dec == '0)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_TIMEOUT;
                    end
                end
                else
                begin
                    advance = 1'b1;
                    priority if (pos_reg <= 4'd1)
                    begin
                        if (b != HDR_BYTE)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_HEADER;
                        end
                    end
                    else if (pos_reg == 4'd2)
                    begin
                        if (b != cfg.expected_id && cfg.expected_id != ANY_ID)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_ID;
                        end
                    end
                    else if (pos_reg == 4'd3)
                    begin
                        if (b < LEN_MIN || b > LEN_MAX)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_LENGTH;
                        end
                        else
                        begin
                            flen_next = len_calc;
                            if (len_calc > len_limit)
                            begin
                                finish     = 1'b1;
                                fin_status = ST_TOO_LONG;
                            end
                        end
                    end
                    else if (pos_reg == 4'd4)
                    begin
                        if (b != cfg.expected_cmd)
                        begin
                            finish     = 1'b1;
                            fin_status = ST_COMMAND;
                        end
                    end
                    else
                    begin
                        if (4'(pos_reg + 4'd1) == flen_reg)
                        begin
                            // checksum byte closes the frame
                            finish     = 1'b1;
                            fin_status = (b == ~sum_reg) ? ST_OK : ST_CHECKSUM;
                        end
                        else if (slot >= {1'b0, eff_count} || slot >= 4'(PARAM_SLOTS))
                        begin
                            finish     = 1'b1;
                            fin_status = ST_TOO_LONG;
                        end
                        else
                        begin
                            store_we = 1'b1;
                        end
                    end
                end
            end
        end

        if (finish)
        begin
            active_next = 1'b0;
        end
        else if (advance)
        begin
            if (pos_reg > 4'd1)
            begin
                sum_next = sum_reg + b;
            end
            pos_next = pos_reg + 4'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (finish)
        begin
            out_valid_next            = 1'b1;
            out_data_next             = '0;
            out_data_next.status      = fin_status;
            if (fin_status == ST_OK)
            begin
                out_data_next.param_count = n_params;
                out_data_next.param_0 = (n_params > 3'd0) ? store_reg[0] : '0;
                out_data_next.param_1 = (n_params > 3'd1) ? store_reg[1] : '0;
                out_data_next.param_2 = (n_params > 3'd2) ? store_reg[2] : '0;
                out_data_next.param_3 = (n_params > 3'd3) ? store_reg[3] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            flen_reg      <= FRAME_LEN_INIT;
            sum_reg       <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            flen_reg      <= flen_next;
            sum_reg       <= sum_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (store_we)
        begin
            store_reg[slot[PIDX_W-1:0]] <= b;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/servo_reply_frame_checker_core.sv
// ----------------------------------------------------------------------------
// servo_reply_frame_checker_core: an accepted word passes through the queue stage
// and the registered output before its status word appears
// throughput is one word per cycle while the output is not held by out_stall
// reset clears the frame state, queue and output valid; registers take defaults
// ----------------------------------------------------------------------------
module servo_reply_frame_checker_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  srfc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output srfc_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [srfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import srfc_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic               q_full;
    logic               push;
    q_entry_t           push_entry;
    logic               pop;
    logic               head_valid;
    q_entry_t           head_entry;
    logic [QCNT_W-1:0]  q_level;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_ID:    cfg_next.expected_id          = cfg_wdata;
                CFG_EXPECTED_CMD:   cfg_next.expected_cmd         = cfg_wdata;
                CFG_EXPECTED_COUNT: cfg_next.expected_param_count = cfg_wdata[2:0];
                CFG_PER_BYTE_MS:    cfg_next.per_byte_ms          = cfg_wdata;
                CFG_EXTRA_MS:       cfg_next.extra_ms             = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_id          <= ANY_ID;
            cfg_reg.expected_cmd         <= 8'd0;
            cfg_reg.expected_param_count <= 3'd0;
            cfg_reg.per_byte_ms          <= 8'd15;
            cfg_reg.extra_ms             <= 8'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srfc_front u_front
    (
        .in_data    (in_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    srfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .full       (q_full),
        .level      (q_level)
    );

    srfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    a_err_no_params: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.param_count == 3'd0)
        else $error("error status carries parameters");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.param_count <= 3'(PARAM_SLOTS))
        else $error("parameter count out of range");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QCNT_W'(QUEUE_DEPTH) && (in_stall == (q_level == QCNT_W'(QUEUE_DEPTH))))
        else $error("queue level inconsistent with stall");

    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != '0 && !out_valid |=> q_level <= $past(q_level))
        else $error("queue did not drain with free output");
`endif

endmodule
